// File: sv/adsr_pkg.sv
package adsr_pkg;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 3;
  localparam int KNOB_W   = 10;
  localparam int LEVEL_W  = 8;
  localparam int PHASE_W  = 3;
  localparam int DIR_W    = 2;
  localparam int PERIOD_W = 12;
  localparam int ERR_W    = 14;

  // Parameter defaults.
  localparam int SMOOTH_WEIGHT_DEF = 6;
  localparam int TICKS_DEF         = 4;

  // Knob file.
  localparam int NUM_KNOBS = 5;
  localparam int KNOB_ATTACK    = 0;
  localparam int KNOB_DECAY     = 1;
  localparam int KNOB_SUS_LEVEL = 2;
  localparam int KNOB_SUS_TIME  = 3;
  localparam int KNOB_RELEASE   = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_KNOB    = 2'd2;

  // Envelope phase codes.
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

  // Ramp direction codes.
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_RAMP,
    S_TIMER,
    S_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic trigger;
    logic div_init;
    logic div_step;
    logic ramp_sub;
    logic ramp_step;
    logic timer_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ch_ok;
    logic             ramp_on;
    logic             err_neg;
  } dp_status_t;

endpackage

// File: sv/adsr_envelope_generator_unit.sv
// From input transfer to out_valid the controller passes IDLE and DECODE, then: for a trigger
// DONE; for a knob sample on a valid channel DIV (weighted sum, then reciprocal multiply) and
// DONE; for a PWM tick without a ramp TIMER and DONE, or with a ramp RAMP once per level step
// (at most 64), then TIMER and DONE; for other commands DONE. DONE waits while a result is unread.
// A new item is taken only in IDLE; the next item is taken while a result waits.
// Reset (rst_n low at a clock edge) clears knobs, phase, level, ramp, timer and handshake state.
module adsr_envelope_generator_unit
  import adsr_pkg::*;
#(
  parameter int SMOOTH_WEIGHT        = SMOOTH_WEIGHT_DEF,
  parameter int TICKS_PER_TIMER_STEP = TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [CHAN_W-1:0]  in_knob_channel,
  input  logic [KNOB_W-1:0]  in_knob_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] out_level,
  output logic [PHASE_W-1:0] out_phase,
  output logic               out_active
);

  dp_cmd_t    ctl;
  dp_status_t st;

  // Sequencer.
  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  // Envelope state, divider, ramp and timer.
  adsr_datapath #(
    .SMOOTH_WEIGHT        (SMOOTH_WEIGHT),
    .TICKS_PER_TIMER_STEP (TICKS_PER_TIMER_STEP)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_knob_channel (in_knob_channel),
    .in_knob_sample  (in_knob_sample),
    .ctl             (ctl),
    .st              (st),
    .out_level       (out_level),
    .out_phase       (out_phase),
    .out_active      (out_active)
  );

endmodule

// File: sv/adsr_ctrl.sv
module adsr_ctrl
  import adsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    ctl
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.cmd)
          CMD_TRIGGER: begin
            ctl.trigger = 1'b1;
            state_nxt   = S_DONE;
          end
          CMD_TICK: begin
            if (st.ramp_on) begin
              ctl.ramp_sub = 1'b1;
              state_nxt    = S_RAMP;
            end else begin
              state_nxt = S_TIMER;
            end
          end
          CMD_KNOB: begin
            if (st.ch_ok) begin
              ctl.div_init = 1'b1;
              state_nxt    = S_DIV;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        // The reciprocal multiply finishes the smoothed value in this state.
        ctl.div_step = 1'b1;
        state_nxt    = S_DONE;
      end
      S_RAMP: begin
        // One level step per cycle while the error term is negative.
        if (st.err_neg) begin
          ctl.ramp_step = 1'b1;
        end else begin
          state_nxt = S_TIMER;
        end
      end
      S_TIMER: begin
        ctl.timer_step = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result register is full from load until its transfer.
  always_comb begin
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/adsr_datapath.sv
module adsr_datapath
  import adsr_pkg::*;
#(
  parameter int SMOOTH_WEIGHT        = SMOOTH_WEIGHT_DEF,
  parameter int TICKS_PER_TIMER_STEP = TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [CHAN_W-1:0]  in_knob_channel,
  input  logic [KNOB_W-1:0]  in_knob_sample,
  input  dp_cmd_t            ctl,
  output dp_status_t         st,
  output logic [LEVEL_W-1:0] out_level,
  output logic [PHASE_W-1:0] out_phase,
  output logic               out_active
);

  // Division by the smoothing divisor as a multiply by a rounded-up reciprocal.
  localparam int DIVISOR  = SMOOTH_WEIGHT + 1;
  localparam int NUM_W    = KNOB_W + $clog2(DIVISOR);
  localparam int RECIP_SH = NUM_W + $clog2(DIVISOR);
  localparam int RECIP_W  = NUM_W + 1;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + DIVISOR - 1) / DIVISOR);
  localparam int PS_W  = (TICKS_PER_TIMER_STEP > 1) ? $clog2(TICKS_PER_TIMER_STEP) : 1;
  localparam logic [PS_W-1:0] PS_LAST = PS_W'(TICKS_PER_TIMER_STEP - 1);

  // Attack, decay and release times never go below one.
  function automatic logic [KNOB_W-1:0] floor_one(input logic [KNOB_W-1:0] t);
    floor_one = (t == '0) ? KNOB_W'(1) : t;
  endfunction

  // Envelope state.
  logic [KNOB_W-1:0]   knob_r [NUM_KNOBS];
  logic [KNOB_W-1:0]   knob_nxt [NUM_KNOBS];
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [LEVEL_W-1:0]  delta_r, delta_nxt;
  logic [DIR_W-1:0]    dir_r, dir_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [ERR_W-1:0]    error_r, error_nxt;
  logic [KNOB_W-1:0]   limit_r, limit_nxt;
  logic [KNOB_W-1:0]   pcount_r, pcount_nxt;
  logic [PS_W-1:0]     prescale_r, prescale_nxt;

  // Captured item, weighted sum and result register.
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [CHAN_W-1:0]   ch_r, ch_nxt;
  logic [KNOB_W-1:0]   sample_r, sample_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;
  logic [PHASE_W-1:0]  out_phase_r, out_phase_nxt;

  // Working signals.
  logic [KNOB_W-1:0]   knob_sel;
  logic [PROD_W-1:0]   prod;
  logic [KNOB_W-1:0]   quo;
  logic [KNOB_W-1:0]   pcount_inc;
  logic [KNOB_W-1:0]   t_fire;
  logic                ramp_load;
  logic [LEVEL_W-1:0]  ramp_tgt;
  logic [KNOB_W-1:0]   ramp_time;

  // Registers with a defined reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KNOBS; k++) begin
        knob_r[k] <= '0;
      end
      phase_r    <= PH_IDLE;
      level_r    <= '0;
      delta_r    <= '0;
      dir_r      <= DIR_NONE;
      period_r   <= '0;
      error_r    <= '0;
      limit_r    <= '0;
      pcount_r   <= '0;
      prescale_r <= '0;
    end else begin
      for (int k = 0; k < NUM_KNOBS; k++) begin
        knob_r[k] <= knob_nxt[k];
      end
      phase_r    <= phase_nxt;
      level_r    <= level_nxt;
      delta_r    <= delta_nxt;
      dir_r      <= dir_nxt;
      period_r   <= period_nxt;
      error_r    <= error_nxt;
      limit_r    <= limit_nxt;
      pcount_r   <= pcount_nxt;
      prescale_r <= prescale_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ch_r        <= ch_nxt;
    sample_r    <= sample_nxt;
    num_r       <= num_nxt;
    out_level_r <= out_level_nxt;
    out_phase_r <= out_phase_nxt;
  end

  // Knob selected by the captured channel.
  always_comb begin
    knob_sel = '0;
    for (int k = 0; k < NUM_KNOBS; k++) begin
      if (ch_r == CHAN_W'(k)) begin
        knob_sel = knob_r[k];
      end
    end
  end

  // Quotient of the weighted sum; exact over the whole range of the sum.
  assign prod = PROD_W'(num_r) * PROD_W'(RECIP);
  assign quo  = prod[RECIP_SH +: KNOB_W];

  assign pcount_inc = pcount_r + KNOB_W'(1);

  // Next-state logic for every datapath command.
  always_comb begin
    for (int k = 0; k < NUM_KNOBS; k++) begin
      knob_nxt[k] = knob_r[k];
    end
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    delta_nxt     = delta_r;
    dir_nxt       = dir_r;
    period_nxt    = period_r;
    error_nxt     = error_r;
    limit_nxt     = limit_r;
    pcount_nxt    = pcount_r;
    prescale_nxt  = prescale_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    sample_nxt    = sample_r;
    num_nxt       = num_r;
    out_level_nxt = out_level_r;
    out_phase_nxt = out_phase_r;
    t_fire        = '0;
    ramp_load     = 1'b0;
    ramp_tgt      = '0;
    ramp_time     = '0;

    // Capture the item at its transfer.
    if (ctl.load_in) begin
      cmd_nxt    = in_cmd;
      ch_nxt     = in_knob_channel;
      sample_nxt = in_knob_sample;
    end

    // Trigger: restart attack from the present level.
    if (ctl.trigger) begin
      t_fire     = floor_one(knob_r[KNOB_ATTACK]);
      phase_nxt  = PH_ATTACK;
      pcount_nxt = '0;
      limit_nxt  = t_fire;
      ramp_load  = 1'b1;
      ramp_tgt   = LEVEL_MAX;
      ramp_time  = t_fire;
    end

    // Knob smoothing: old value times the weight plus the new sample.
    if (ctl.div_init) begin
      num_nxt = NUM_W'(knob_sel) * NUM_W'(SMOOTH_WEIGHT) + NUM_W'(sample_r);
    end

    // Store the smoothed value into the selected knob.
    if (ctl.div_step) begin
      for (int k = 0; k < NUM_KNOBS; k++) begin
        if (ch_r == CHAN_W'(k)) begin
          knob_nxt[k] = quo;
        end
      end
    end

    // Ramp: take the delta off the error, then step while it is negative.
    if (ctl.ramp_sub) begin
      error_nxt = error_r - ERR_W'(delta_r);
    end

    if (ctl.ramp_step) begin
      if (dir_r == DIR_UP) begin
        if (level_r != LEVEL_MAX) begin
          level_nxt = level_r + LEVEL_W'(1);
        end
      end else begin
        if (level_r != '0) begin
          level_nxt = level_r - LEVEL_W'(1);
        end
      end
      error_nxt = error_r + ERR_W'(period_r);
    end

    // Phase timer with prescaler; a firing moves the envelope on.
    if (ctl.timer_step && (phase_r != PH_IDLE)) begin
      if (prescale_r == PS_LAST) begin
        prescale_nxt = '0;
        if (pcount_inc >= limit_r) begin
          pcount_nxt = '0;
          case (phase_r)
            PH_ATTACK: begin
              t_fire    = floor_one(knob_r[KNOB_DECAY]);
              phase_nxt = PH_DECAY;
              limit_nxt = t_fire;
              ramp_load = 1'b1;
              ramp_tgt  = knob_r[KNOB_SUS_LEVEL][KNOB_W-1:2];
              ramp_time = t_fire;
            end
            PH_DECAY: begin
              phase_nxt = PH_SUSTAIN;
              limit_nxt = knob_r[KNOB_SUS_TIME];
              dir_nxt   = DIR_NONE;
            end
            PH_SUSTAIN: begin
              t_fire    = floor_one(knob_r[KNOB_RELEASE]);
              phase_nxt = PH_RELEASE;
              limit_nxt = t_fire;
              ramp_load = 1'b1;
              ramp_tgt  = '0;
              ramp_time = t_fire;
            end
            PH_RELEASE: begin
              phase_nxt = PH_IDLE;
              dir_nxt   = DIR_NONE;
              level_nxt = '0;
            end
            default: begin
            end
          endcase
        end else begin
          pcount_nxt = pcount_inc;
        end
      end else begin
        prescale_nxt = prescale_r + PS_W'(1);
      end
    end

    // Ramp setup: distance and direction from the present level.
    if (ramp_load) begin
      if (ramp_tgt > level_r) begin
        delta_nxt = ramp_tgt - level_r;
        dir_nxt   = DIR_UP;
      end else begin
        delta_nxt = level_r - ramp_tgt;
        dir_nxt   = DIR_DOWN;
      end
      period_nxt = {ramp_time, 2'b00};
      error_nxt  = ERR_W'({ramp_time, 1'b0});
    end

    // Result register.
    if (ctl.load_out) begin
      out_level_nxt = level_r;
      out_phase_nxt = phase_r;
    end
  end

  // Status to the controller.
  always_comb begin
    st.cmd      = cmd_r;
    st.ch_ok    = (ch_r < CHAN_W'(NUM_KNOBS));
    st.ramp_on  = (dir_r != DIR_NONE) && (period_r != '0);
    st.err_neg  = error_r[ERR_W-1];
  end

  assign out_level  = out_level_r;
  assign out_phase  = out_phase_r;
  assign out_active = (out_phase_r != PH_IDLE);

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import adsr_pkg::*;

  // The command code that the block must pass over without any change.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 1525;
  localparam int DRAIN_CYCLES    = 100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PERIOD_SCALE    = 4;
  localparam int PHASE_COUNT_MASK = 'h3FF;
  localparam int PERIOD_MASK     = 'hFFF;

  typedef enum int {
    PACE_FULL,
    PACE_SEND_SLOW,
    PACE_RECV_SLOW,
    PACE_BOTH_LIGHT
  } pace_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0] phase;
    logic               active;
  } env_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] chan;
    logic [KNOB_W-1:0] reading;
    logic              known;
    env_result_t       result;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [CMD_W-1:0]   in_cmd = CMD_TICK;
  logic [CHAN_W-1:0]  in_knob_channel = '0;
  logic [KNOB_W-1:0]  in_knob_sample = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [PHASE_W-1:0] out_phase;
  logic               out_active;

  // Envelope state as the block should hold it.
  int                 knob_avg [NUM_KNOBS];
  logic [PHASE_W-1:0] env_phase = PH_IDLE;
  int                 env_level = 0;
  logic [DIR_W-1:0]   slope_dir = DIR_NONE;
  int                 slope_delta = 0;
  int                 slope_period = 0;
  int                 slope_err = 0;
  int                 span_limit = 0;
  int                 span_count = 0;
  int                 tick_div = 0;

  env_result_t        expected_results [$];
  pace_t              pace = PACE_FULL;
  int                 hold_request = 0;
  int                 mismatches = 0;
  int                 sent_items = 0;

  adsr_envelope_generator_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_knob_channel (in_knob_channel),
    .in_knob_sample  (in_knob_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_phase       (out_phase),
    .out_active      (out_active)
  );

  always #2 clk = ~clk;

  // Knob times of zero are raised to one, except the sustain time.
  function automatic int at_least_one(int t);
    return (t < 1) ? 1 : t;
  endfunction

  // Set up a linear ramp from the present level toward the target.
  function automatic void start_slope(int target, int span);
    if (target > env_level) begin
      slope_delta = target - env_level;
      slope_dir   = DIR_UP;
    end else begin
      slope_delta = env_level - target;
      slope_dir   = DIR_DOWN;
    end
    slope_period = (span * PERIOD_SCALE) & PERIOD_MASK;
    slope_err    = slope_period / 2;
  endfunction

  // Apply one command to the envelope state and return the result it shows afterwards.
  function automatic env_result_t predict_envelope(logic [CMD_W-1:0] cmd,
                                                   logic [CHAN_W-1:0] chan,
                                                   logic [KNOB_W-1:0] reading);
    env_result_t r;
    int          span;
    case (cmd)
      CMD_TRIGGER: begin
        span       = at_least_one(knob_avg[KNOB_ATTACK]);
        env_phase  = PH_ATTACK;
        span_count = 0;
        start_slope(LEVEL_MAX, span);
        span_limit = span;
      end
      CMD_TICK: begin
        // Bresenham step: move the level until the error is no longer negative.
        if (slope_dir != DIR_NONE && slope_period != 0) begin
          slope_err = slope_err - slope_delta;
          while (slope_err < 0) begin
            if (slope_dir == DIR_UP) begin
              if (env_level < LEVEL_MAX) env_level++;
            end else begin
              if (env_level > 0) env_level--;
            end
            slope_err = slope_err + slope_period;
          end
        end
        // Phase timer, held while idle.
        if (env_phase != PH_IDLE) begin
          tick_div++;
          if (tick_div >= TICKS_DEF) begin
            tick_div   = 0;
            span_count = (span_count + 1) & PHASE_COUNT_MASK;
            if (span_count >= span_limit) begin
              span_count = 0;
              case (env_phase)
                PH_ATTACK: begin
                  env_phase  = PH_DECAY;
                  span       = at_least_one(knob_avg[KNOB_DECAY]);
                  span_limit = span;
                  start_slope(knob_avg[KNOB_SUS_LEVEL] >> 2, span);
                end
                PH_DECAY: begin
                  env_phase  = PH_SUSTAIN;
                  span_limit = knob_avg[KNOB_SUS_TIME];
                  slope_dir  = DIR_NONE;
                end
                PH_SUSTAIN: begin
                  env_phase  = PH_RELEASE;
                  span       = at_least_one(knob_avg[KNOB_RELEASE]);
                  span_limit = span;
                  start_slope(0, span);
                end
                PH_RELEASE: begin
                  env_phase = PH_IDLE;
                  slope_dir = DIR_NONE;
                  env_level = 0;
                end
                default: ;
              endcase
            end
          end
        end
      end
      CMD_KNOB: begin
        if (chan < NUM_KNOBS) begin
          knob_avg[chan] = ((knob_avg[chan] * SMOOTH_WEIGHT_DEF + reading) /
                            (SMOOTH_WEIGHT_DEF + 1)) & PHASE_COUNT_MASK;
        end
      end
      default: ;
    endcase
    r.level  = env_level[LEVEL_W-1:0];
    r.phase  = env_phase;
    r.active = (env_phase != PH_IDLE);
    return r;
  endfunction

  function automatic stim_row_t make_row(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] chan,
                                         logic [KNOB_W-1:0] reading, logic known = 1'b0,
                                         logic [LEVEL_W-1:0] level = '0,
                                         logic [PHASE_W-1:0] phase = PH_IDLE,
                                         logic active = 1'b0);
    stim_row_t row;
    row.cmd           = cmd;
    row.chan          = chan;
    row.reading       = reading;
    row.known         = known;
    row.result.level  = level;
    row.result.phase  = phase;
    row.result.active = active;
    return row;
  endfunction

  // Offer one item after a random gap and record its expected result on transfer.
  task automatic send_item(input stim_row_t row);
    int          gap;
    int          idle_pct;
    env_result_t predicted;
    idle_pct = (pace == PACE_SEND_SLOW) ? 85 : (pace == PACE_BOTH_LIGHT) ? 10 : 0;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= row.cmd;
    in_knob_channel <= row.chan;
    in_knob_sample  <= row.reading;
    do @(posedge clk); while (!in_ready);
    predicted = predict_envelope(row.cmd, row.chan, row.reading);
    expected_results.push_back(row.known ? row.result : predicted);
    sent_items++;
  endtask

  // Stimulus: directed table first, then random envelope episodes and noise bursts.
  initial begin : stimulus
    stim_row_t directed [$];
    stim_row_t row;
    int        burst;
    int        pick;
    int        start_count;
    int        progress;
    bit        noise;
    bit        hold_done;
    for (int k = 0; k < NUM_KNOBS; k++) knob_avg[k] = 0;
    hold_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle behavior right after reset, ignored commands and out-of-range knobs.
    directed.push_back(make_row(CMD_TICK, 0, 0, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_UNUSED, 7, 1023, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, 5, 1023, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, 6, 0, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, 7, 1023, 1'b1, 0, PH_IDLE, 1'b0));
    // Short attack, zero decay, full-scale sustain level sample, zero sustain time, short release.
    directed.push_back(make_row(CMD_KNOB, KNOB_ATTACK, 7, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, KNOB_DECAY, 0, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, KNOB_SUS_LEVEL, 1023, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, KNOB_SUS_TIME, 0, 1'b1, 0, PH_IDLE, 1'b0));
    directed.push_back(make_row(CMD_KNOB, KNOB_RELEASE, 14, 1'b1, 0, PH_IDLE, 1'b0));
    // Trigger from idle leaves the level where it was.
    directed.push_back(make_row(CMD_TRIGGER, 0, 0, 1'b1, 0, PH_ATTACK, 1'b1));
    for (int i = 0; i < 4; i++) directed.push_back(make_row(CMD_TICK, 0, 0));
    // Retrigger while the envelope is running.
    directed.push_back(make_row(CMD_TRIGGER, 7, 1023));
    for (int i = 0; i < 8; i++) directed.push_back(make_row(CMD_TICK, 3, 512));
    directed.push_back(make_row(CMD_KNOB, KNOB_ATTACK, 1023));

    foreach (directed[i]) send_item(directed[i]);

    // Random part: mostly full envelopes with small knob settings, some noise.
    start_count = sent_items;
    while (sent_items - start_count < RANDOM_ITEMS) begin
      progress = sent_items - start_count;
      pace = pace_t'((progress * 4) / RANDOM_ITEMS);
      noise = ($urandom_range(9) == 0);
      if (noise) begin
        burst = $urandom_range(30, 10);
      end else begin
        burst = $urandom_range(400, 40);
        send_item(make_row(CMD_TRIGGER, CHAN_W'($urandom_range(7)),
                           KNOB_W'($urandom_range(1023))));
      end
      for (int n = 0; n < burst && sent_items - start_count < RANDOM_ITEMS; n++) begin
        // One long receiver hold-off while the sender keeps offering items.
        if (!hold_done && pace == PACE_FULL && sent_items - start_count >= 50) begin
          hold_request = HOLD_OFF_CYCLES;
          hold_done    = 1'b1;
        end
        row  = make_row(CMD_TICK, CHAN_W'($urandom_range(7)), KNOB_W'($urandom_range(1023)));
        pick = $urandom_range(99);
        if (noise) begin
          row.cmd = CMD_W'($urandom_range(3));
          if (row.cmd == CMD_KNOB && $urandom_range(1) == 1) begin
            row.reading = KNOB_W'($urandom_range(12));
          end
        end else if (pick < 70) begin
          row.cmd = CMD_TICK;
        end else if (pick < 93) begin
          row.cmd     = CMD_KNOB;
          row.chan    = CHAN_W'(($urandom_range(9) == 0) ? $urandom_range(7, 5) :
                                                            $urandom_range(4));
          row.reading = KNOB_W'(($urandom_range(99) < 3) ? $urandom_range(1023) :
                                                            $urandom_range(12));
        end else if (pick < 99) begin
          row.cmd = CMD_UNUSED;
        end else begin
          row.cmd = CMD_TRIGGER;
        end
        send_item(row);
      end
    end
    in_valid <= 1'b0;

    // Let every expected result arrive, then watch for stray ones.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: compare each transfer with the oldest expectation and pace out_ready.
  always @(posedge clk) begin : result_check
    env_result_t want;
    int          hold_left;
    int          stall_pct;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: level %0d phase %0d active %0d",
               out_level, out_phase, out_active);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_level !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, out_level);
          mismatches++;
        end
        if (out_phase !== want.phase) begin
          $error("phase: expected %0d, actual %0d", want.phase, out_phase);
          mismatches++;
        end
        if (out_active !== want.active) begin
          $error("active: expected %0d, actual %0d", want.active, out_active);
          mismatches++;
        end
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    stall_pct = (pace == PACE_RECV_SLOW) ? 85 : (pace == PACE_BOTH_LIGHT) ? 10 : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/adsr_pkg.sv
sv/adsr_ctrl.sv
sv/adsr_datapath.sv
sv/adsr_envelope_generator_unit.sv
tb/tb.sv
